// ===== rtl/dcti_pkg.sv =====
// ----------------------------------------------------------------------------
// dcti_pkg
// Types, constants and helpers shared by the diode clipper table interpolator.
// ----------------------------------------------------------------------------
package dcti_pkg;

  localparam int unsigned TABLE_SIZE = 2048;

  // Item operation codes
  localparam logic OP_SAMPLE     = 1'b0;
  localparam logic OP_TABLE_LOAD = 1'b1;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_INPUT_GAIN  = 3'd0,
    CFG_HP_B0       = 3'd1,
    CFG_HP_A1       = 3'd2,
    CFG_COEF_PREV1  = 3'd3,
    CFG_COEF_PREV2  = 3'd4,
    CFG_COEF_FILT   = 3'd5,
    CFG_GRID_LOW    = 3'd6,
    CFG_GRID_STEP_INV = 3'd7
  } cfg_reg_e;

  localparam logic [30:0]        RST_INPUT_GAIN    = 31'd16777216;
  localparam logic [30:0]        RST_HP_B0         = 31'd16777216;
  localparam logic signed [31:0] RST_GRID_LOW      = -32'sd512487016;
  localparam logic [30:0]        RST_GRID_STEP_INV = 31'd137264180;

  // Datapath widths
  localparam int unsigned MUL_W  = 33;  // signed multiplier operand
  localparam int unsigned PROD_W = 66;  // full product
  localparam int unsigned SH_W   = 42;  // product >>> 24
  localparam int unsigned BU_W   = 40;  // b0 term
  localparam int unsigned POS_W  = 44;  // grid position, Q.24
  localparam int unsigned T_W    = 31;  // saturated fraction
  localparam int unsigned D_W    = 33;  // table difference

  // Shared multiplier operand select
  typedef enum logic [2:0] {
    MUL_GAIN,
    MUL_B0,
    MUL_A1,
    MUL_C1,
    MUL_C2,
    MUL_CF,
    MUL_POS,
    MUL_T
  } mul_sel_e;

  // Table read address select
  typedef enum logic [1:0] {
    RD_FIRST,
    RD_LAST,
    RD_IP,
    RD_IP_NEXT
  } rd_sel_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_MUL_G,
    ST_SAT_UL,
    ST_MUL_B0,
    ST_HP_Y,
    ST_MUL_A1,
    ST_HP_MEM,
    ST_END_RD,
    ST_END_RES,
    ST_MUL_C1,
    ST_MUL_C2,
    ST_MUL_CF,
    ST_ACC3,
    ST_SAT_C,
    ST_MUL_POS,
    ST_POS,
    ST_IDX,
    ST_FRAC,
    ST_RD2,
    ST_DIFF,
    ST_MUL_T,
    ST_RES,
    ST_OUT
  } ctrl_state_e;

  typedef struct packed {
    logic     in_latch;
    logic     tbl_wr;
    logic     mul_en;
    mul_sel_e mul_sel;
    logic     ld_ul;
    logic     ld_y;
    logic     ld_hpm;
    logic     acc_ld;
    logic     acc_add;
    logic     ld_diff;
    logic     ld_pos;
    logic     ld_ip;
    logic     ld_t;
    logic     rd_en;
    rd_sel_e  rd_sel;
    logic     ld_a;
    logic     ld_d;
    logic     ld_res_end;
    logic     ld_res_interp;
    logic     out_load;
  } dcti_cmd_t;

  typedef struct packed {
    logic below;
    logic above;
  } dcti_sts_t;

  function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
    logic signed [31:0] r;
    if (v > 48'sd2147483647) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -48'sd2147483648) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/dcti_in_if.sv =====
// ----------------------------------------------------------------------------
// dcti_in_if
// Input item channel: sample or table load, valid/ready handshake.
// ----------------------------------------------------------------------------
interface dcti_in_if;
  logic               valid;
  logic               ready;
  logic               operation;
  logic signed [31:0] sample_in;
  logic [10:0]        table_index;
  logic signed [31:0] table_value;

  modport source (
    output valid, operation, sample_in, table_index, table_value,
    input  ready
  );
  modport sink (
    input  valid, operation, sample_in, table_index, table_value,
    output ready
  );
endinterface

// ===== rtl/dcti_out_if.sv =====
// ----------------------------------------------------------------------------
// dcti_out_if
// Output item channel: clipped sample, valid/ready handshake.
// ----------------------------------------------------------------------------
interface dcti_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] sample_out;

  modport source (
    output valid, sample_out,
    input  ready
  );
  modport sink (
    input  valid, sample_out,
    output ready
  );
endinterface

// ===== rtl/diode_clipper_table_interp_unit.sv =====
// ----------------------------------------------------------------------------
// diode_clipper_table_interp_unit
// Gain, first-order high-pass and table-interpolated diode clipper per item.
// ----------------------------------------------------------------------------
//  channel   dir  handshake        payload
//  in_ch     in   valid / ready    operation, sample_in, table_index, table_value
//  out_ch    out  valid / ready    sample_out
//  cfg       in   cfg_we_i         cfg_index_i, cfg_wdata_i
//
//  A sample inside the grid uses the multiplier eight times and reads the table
//  twice; a sample clamped to a table end uses it three times and reads once.
//  Table load: written on accept, no result. The sequence is set by the one shared 33x33
//  multiplier (eight products) and the single table read port.
//  Reset is asynchronous active low; the table is not cleared.
//  A stalled output holds its item; the next item is taken meanwhile and
//  waits for the output register before its result is released.
// ----------------------------------------------------------------------------
module diode_clipper_table_interp_unit #(
  parameter int unsigned TableSize = dcti_pkg::TABLE_SIZE
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_wdata_i,
  dcti_in_if.sink     in_ch,
  dcti_out_if.source  out_ch
);

  dcti_pkg::dcti_cmd_t cmd;
  dcti_pkg::dcti_sts_t sts;

  dcti_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_ch.valid),
    .in_operation_i (in_ch.operation),
    .in_ready_o     (in_ch.ready),
    .out_valid_o    (out_ch.valid),
    .out_ready_i    (out_ch.ready),
    .sts_i          (sts),
    .cmd_o          (cmd)
  );

  dcti_dpath #(
    .TableSize (TableSize)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .sample_in_i   (in_ch.sample_in),
    .table_index_i (in_ch.table_index),
    .table_value_i (in_ch.table_value),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .sample_out_o  (out_ch.sample_out)
  );

endmodule

// ===== rtl/dcti_ram.sv =====
// ----------------------------------------------------------------------------
// dcti_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dcti_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 2048,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/dcti_ctrl.sv =====
// ----------------------------------------------------------------------------
// dcti_ctrl
// Sequencer: steps the shared multiplier and table reads through one item.
// ----------------------------------------------------------------------------
module dcti_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_operation_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  dcti_pkg::dcti_sts_t sts_i,
  output dcti_pkg::dcti_cmd_t cmd_o
);

  dcti_pkg::ctrl_state_e state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic accept;

  assign in_ready_o  = (state_q == dcti_pkg::ST_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dcti_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.mul_sel = dcti_pkg::MUL_GAIN;
    cmd_o.rd_sel  = dcti_pkg::RD_FIRST;

    unique case (state_q)
      dcti_pkg::ST_IDLE: begin
        cmd_o.in_latch = accept && (in_operation_i == dcti_pkg::OP_SAMPLE);
        cmd_o.tbl_wr   = accept && (in_operation_i == dcti_pkg::OP_TABLE_LOAD);
        if (accept && (in_operation_i == dcti_pkg::OP_SAMPLE)) begin
          state_d = dcti_pkg::ST_MUL_G;
        end
      end
      dcti_pkg::ST_MUL_G: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = dcti_pkg::MUL_GAIN;
        state_d       = dcti_pkg::ST_SAT_UL;
      end
      dcti_pkg::ST_SAT_UL: begin
        cmd_o.ld_ul = 1'b1;
        state_d     = dcti_pkg::ST_MUL_B0;
      end
      dcti_pkg::ST_MUL_B0: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = dcti_pkg::MUL_B0;
        state_d       = dcti_pkg::ST_HP_Y;
      end
      dcti_pkg::ST_HP_Y: begin
        cmd_o.ld_y = 1'b1;
        state_d    = dcti_pkg::ST_MUL_A1;
      end
      dcti_pkg::ST_MUL_A1: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = dcti_pkg::MUL_A1;
        state_d       = dcti_pkg::ST_HP_MEM;
      end
      dcti_pkg::ST_HP_MEM: begin
        cmd_o.ld_hpm = 1'b1;
        // lower test first: it wins for a positive grid_low
        if (sts_i.below || sts_i.above) begin
          state_d = dcti_pkg::ST_END_RD;
        end else begin
          state_d = dcti_pkg::ST_MUL_C1;
        end
      end
      dcti_pkg::ST_END_RD: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = sts_i.below ? dcti_pkg::RD_FIRST : dcti_pkg::RD_LAST;
        state_d      = dcti_pkg::ST_END_RES;
      end
      dcti_pkg::ST_END_RES: begin
        cmd_o.ld_res_end = 1'b1;
        state_d          = dcti_pkg::ST_OUT;
      end
      dcti_pkg::ST_MUL_C1: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = dcti_pkg::MUL_C1;
        state_d       = dcti_pkg::ST_MUL_C2;
      end
      dcti_pkg::ST_MUL_C2: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = dcti_pkg::MUL_C2;
        cmd_o.acc_ld  = 1'b1;
        state_d       = dcti_pkg::ST_MUL_CF;
      end
      dcti_pkg::ST_MUL_CF: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = dcti_pkg::MUL_CF;
        cmd_o.acc_add = 1'b1;
        state_d       = dcti_pkg::ST_ACC3;
      end
      dcti_pkg::ST_ACC3: begin
        cmd_o.acc_add = 1'b1;
        state_d       = dcti_pkg::ST_SAT_C;
      end
      dcti_pkg::ST_SAT_C: begin
        cmd_o.ld_diff = 1'b1;
        state_d       = dcti_pkg::ST_MUL_POS;
      end
      dcti_pkg::ST_MUL_POS: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = dcti_pkg::MUL_POS;
        state_d       = dcti_pkg::ST_POS;
      end
      dcti_pkg::ST_POS: begin
        cmd_o.ld_pos = 1'b1;
        state_d      = dcti_pkg::ST_IDX;
      end
      dcti_pkg::ST_IDX: begin
        cmd_o.ld_ip = 1'b1;
        state_d     = dcti_pkg::ST_FRAC;
      end
      dcti_pkg::ST_FRAC: begin
        cmd_o.ld_t   = 1'b1;
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = dcti_pkg::RD_IP;
        state_d      = dcti_pkg::ST_RD2;
      end
      dcti_pkg::ST_RD2: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = dcti_pkg::RD_IP_NEXT;
        cmd_o.ld_a   = 1'b1;
        state_d      = dcti_pkg::ST_DIFF;
      end
      dcti_pkg::ST_DIFF: begin
        cmd_o.ld_d = 1'b1;
        state_d    = dcti_pkg::ST_MUL_T;
      end
      dcti_pkg::ST_MUL_T: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = dcti_pkg::MUL_T;
        state_d       = dcti_pkg::ST_RES;
      end
      dcti_pkg::ST_RES: begin
        cmd_o.ld_res_interp = 1'b1;
        state_d             = dcti_pkg::ST_OUT;
      end
      dcti_pkg::ST_OUT: begin
        // wait for the output register to free up
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = dcti_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = dcti_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

endmodule

// ===== rtl/dcti_dpath.sv =====
// ----------------------------------------------------------------------------
// dcti_dpath
// Datapath: config registers, filter state, shared 33x33 multiplier,
// grid position and interpolation arithmetic, solution table.
// ----------------------------------------------------------------------------
module dcti_dpath #(
  parameter int unsigned TableSize = dcti_pkg::TABLE_SIZE
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_index_i,
  input  logic [31:0]         cfg_wdata_i,
  input  logic signed [31:0]  sample_in_i,
  input  logic [10:0]         table_index_i,
  input  logic signed [31:0]  table_value_i,
  input  dcti_pkg::dcti_cmd_t cmd_i,
  output dcti_pkg::dcti_sts_t sts_o,
  output logic signed [31:0]  sample_out_o
);

  localparam int unsigned AW    = $clog2(TableSize);
  localparam int unsigned MW    = dcti_pkg::MUL_W;
  localparam int unsigned PW    = dcti_pkg::PROD_W;
  localparam int unsigned SW    = dcti_pkg::SH_W;
  localparam int unsigned BW    = dcti_pkg::BU_W;
  localparam int unsigned QW    = dcti_pkg::POS_W;
  localparam int unsigned TW    = dcti_pkg::T_W;
  localparam int unsigned DW    = dcti_pkg::D_W;
  localparam int unsigned IP_W  = QW - 24 + 1;
  localparam logic signed [IP_W-1:0] IpMax  = IP_W'(TableSize - 2);
  localparam logic signed [QW-1:0]   TSatHi = QW'(64'sd536870912);
  localparam logic signed [QW-1:0]   TSatLo = -TSatHi;
  localparam logic [AW-1:0]          LastAddr = AW'(TableSize - 1);

  // Configuration
  logic [30:0]        gain_q, b0_q, gsi_q;
  logic signed [31:0] a1_q, cp1_q, cp2_q, cf_q, grid_low_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q     <= dcti_pkg::RST_INPUT_GAIN;
      b0_q       <= dcti_pkg::RST_HP_B0;
      a1_q       <= '0;
      cp1_q      <= '0;
      cp2_q      <= '0;
      cf_q       <= '0;
      grid_low_q <= dcti_pkg::RST_GRID_LOW;
      gsi_q      <= dcti_pkg::RST_GRID_STEP_INV;
    end else if (cfg_we_i) begin
      unique case (dcti_pkg::cfg_reg_e'(cfg_index_i))
        dcti_pkg::CFG_INPUT_GAIN:    gain_q     <= cfg_wdata_i[30:0];
        dcti_pkg::CFG_HP_B0:         b0_q       <= cfg_wdata_i[30:0];
        dcti_pkg::CFG_HP_A1:         a1_q       <= cfg_wdata_i;
        dcti_pkg::CFG_COEF_PREV1:    cp1_q      <= cfg_wdata_i;
        dcti_pkg::CFG_COEF_PREV2:    cp2_q      <= cfg_wdata_i;
        dcti_pkg::CFG_COEF_FILT:     cf_q       <= cfg_wdata_i;
        dcti_pkg::CFG_GRID_LOW:      grid_low_q <= cfg_wdata_i;
        dcti_pkg::CFG_GRID_STEP_INV: gsi_q      <= cfg_wdata_i[30:0];
        default: ;
      endcase
    end
  end

  // Filter and output history
  logic signed [31:0] hpm_q, o1_q, o2_q;

  // Working registers
  logic signed [31:0] x_q, ul_q, y_q, a_q, res_q, out_q;
  logic signed [BW-1:0] bu_q;
  logic signed [SW-1:0] acc_q;
  logic signed [MW-1:0] diff_q;
  logic signed [QW-1:0] pos_q;
  logic [AW-1:0]        ip_q;
  logic signed [TW-1:0] t_q;
  logic signed [DW-1:0] d_q;
  logic signed [PW-1:0] p_q;

  // Shared multiplier
  logic signed [MW-1:0] op_a, op_b;

  always_comb begin
    unique case (cmd_i.mul_sel)
      dcti_pkg::MUL_GAIN: begin op_a = {2'b00, gain_q}; op_b = MW'(x_q);  end
      dcti_pkg::MUL_B0:   begin op_a = {2'b00, b0_q};   op_b = MW'(ul_q); end
      dcti_pkg::MUL_A1:   begin op_a = MW'(a1_q);       op_b = MW'(y_q);  end
      dcti_pkg::MUL_C1:   begin op_a = MW'(cp1_q);      op_b = MW'(o1_q); end
      dcti_pkg::MUL_C2:   begin op_a = MW'(cp2_q);      op_b = MW'(o2_q); end
      dcti_pkg::MUL_CF:   begin op_a = MW'(cf_q);       op_b = MW'(y_q);  end
      dcti_pkg::MUL_POS:  begin op_a = diff_q;          op_b = {2'b00, gsi_q}; end
      dcti_pkg::MUL_T:    begin op_a = MW'(t_q);        op_b = MW'(d_q);  end
      default:            begin op_a = '0;              op_b = '0;        end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      p_q <= op_a * op_b;
    end
  end

  // Product >>> 24, floor rounding
  logic signed [SW-1:0] p_sh24;
  assign p_sh24 = p_q[PW-1:24];

  // Post-multiply arithmetic
  logic signed [47:0]   hpm_sum, res_sum;
  logic signed [31:0]   c_sat;
  logic signed [MW-1:0] diff_d;
  logic                 frac_zero;
  logic signed [IP_W-1:0] ip_dec;
  logic [AW-1:0]        ip_d;
  logic signed [QW-1:0] ip_shift, t_raw;
  logic signed [TW-1:0] t_d;
  logic signed [DW-1:0] d_d;
  logic [31:0]          rdata;

  always_comb begin
    hpm_sum = -48'(bu_q) - 48'(p_sh24);
    res_sum = 48'(a_q) + 48'(p_sh24);
    c_sat   = dcti_pkg::sat32(48'(acc_q));
    diff_d  = MW'(c_sat) - MW'(grid_low_q);

    // index = ceil(pos) - 1, clamped to the table
    frac_zero = (pos_q[23:0] == '0);
    ip_dec    = IP_W'($signed(pos_q[QW-1:24]));
    if (frac_zero) begin
      ip_dec = ip_dec - IP_W'(1);
    end
    if (ip_dec > IpMax) begin
      ip_d = AW'(IpMax);
    end else if (ip_dec < 0) begin
      ip_d = '0;
    end else begin
      ip_d = AW'(ip_dec);
    end

    ip_shift = $signed(QW'({ip_q, 24'h000000}));
    t_raw    = pos_q - ip_shift;
    if (t_raw > TSatHi) begin
      t_d = TW'(TSatHi);
    end else if (t_raw < TSatLo) begin
      t_d = TW'(TSatLo);
    end else begin
      t_d = TW'(t_raw);
    end

    d_d = DW'($signed(rdata)) - DW'(a_q);
  end

  // Range test on the filtered value
  assign sts_o.below = (y_q < grid_low_q);
  assign sts_o.above = (33'(y_q) > -33'(grid_low_q));

  always_ff @(posedge clk_i) begin
    if (cmd_i.in_latch)      x_q    <= sample_in_i;
    if (cmd_i.ld_ul)         ul_q   <= dcti_pkg::sat32(48'(p_sh24));
    if (cmd_i.ld_y) begin
      bu_q <= p_sh24[BW-1:0];
      y_q  <= dcti_pkg::sat32(48'($signed(p_sh24[BW-1:0])) + 48'(hpm_q));
    end
    if (cmd_i.acc_ld)        acc_q  <= p_sh24;
    else if (cmd_i.acc_add)  acc_q  <= acc_q + p_sh24;
    if (cmd_i.ld_diff)       diff_q <= diff_d;
    if (cmd_i.ld_pos)        pos_q  <= p_q[PW-1:22];
    if (cmd_i.ld_ip)         ip_q   <= ip_d;
    if (cmd_i.ld_t)          t_q    <= t_d;
    if (cmd_i.ld_a)          a_q    <= $signed(rdata);
    if (cmd_i.ld_d)          d_q    <= d_d;
    if (cmd_i.ld_res_end)    res_q  <= $signed(rdata);
    else if (cmd_i.ld_res_interp) res_q <= dcti_pkg::sat32(res_sum);
    if (cmd_i.out_load)      out_q  <= res_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hpm_q <= '0;
      o1_q  <= '0;
      o2_q  <= '0;
    end else begin
      if (cmd_i.ld_hpm) begin
        hpm_q <= dcti_pkg::sat32(hpm_sum);
      end
      if (cmd_i.out_load) begin
        o2_q <= o1_q;
        o1_q <= res_q;
      end
    end
  end

  // Solution table
  logic          tbl_we;
  logic [AW-1:0] tbl_raddr;

  assign tbl_we = cmd_i.tbl_wr && (32'(table_index_i) < 32'(TableSize));

  always_comb begin
    unique case (cmd_i.rd_sel)
      dcti_pkg::RD_FIRST:   tbl_raddr = '0;
      dcti_pkg::RD_LAST:    tbl_raddr = LastAddr;
      dcti_pkg::RD_IP:      tbl_raddr = ip_q;
      dcti_pkg::RD_IP_NEXT: tbl_raddr = ip_q + AW'(1);
      default:              tbl_raddr = '0;
    endcase
  end

  dcti_ram #(
    .Width (32),
    .Depth (TableSize)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (AW'(table_index_i)),
    .wdata_i (table_value_i),
    .re_i    (cmd_i.rd_en),
    .raddr_i (tbl_raddr),
    .rdata_o (rdata)
  );

  assign sample_out_o = out_q;

endmodule

// ===== rtl/dcti_checker.sv =====
// ----------------------------------------------------------------------------
// dcti_checker
// Port-level checks on the diode clipper table interpolator.
// ----------------------------------------------------------------------------
module dcti_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        in_operation_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [31:0] sample_out_i
);

  logic in_acc;
  assign in_acc = in_valid_i && in_ready_i;

  // a sample occupies the block after it is taken
  a_sample_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (in_operation_i == dcti_pkg::OP_SAMPLE) |=> !in_ready_i)
    else $error("input ready right after a sample item");

  // a table load finishes in its own cycle
  a_load_quick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (in_operation_i == dcti_pkg::OP_TABLE_LOAD) |=> in_ready_i)
    else $error("block busy after a table load item");

  // a new result appears as the block returns to idle
  a_result_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> in_ready_i)
    else $error("result raised while block busy");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("output item dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(sample_out_i))
    else $error("output item changed while stalled");

endmodule

bind diode_clipper_table_interp_unit dcti_checker u_dcti_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_ch.valid),
  .in_ready_i     (in_ch.ready),
  .in_operation_i (in_ch.operation),
  .out_valid_i    (out_ch.valid),
  .out_ready_i    (out_ch.ready),
  .sample_out_i   (out_ch.sample_out)
);
